FILE: rtl/four_level_page_table_manager_assert.svh
// Assertion macros for the page table manager.
`ifndef FOUR_LEVEL_PAGE_TABLE_MANAGER_ASSERT_SVH
`define FOUR_LEVEL_PAGE_TABLE_MANAGER_ASSERT_SVH
`ifndef SYNTHESIS
`define PTM_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define PTM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define PTM_ASSERT_SAME(label, ante, cons)
`define PTM_ASSERT_NEXT(label, ante, cons)
`endif
`endif

FILE: rtl/ptm_pkg.sv
// Shared types and constants for the page table manager.
`timescale 1ns / 1ps
package ptm_pkg;
  localparam int TABLE_ENTRIES = 512;
  localparam int TABLE_FRAMES  = 64;
  localparam int IDX_W   = $clog2(TABLE_ENTRIES);
  localparam int TBL_W   = $clog2(TABLE_FRAMES);
  localparam int ALLOC_W = $clog2(TABLE_FRAMES + 1);
  localparam int ADDR_W  = TBL_W + IDX_W;
  localparam int VAL_W   = 40;
  localparam int ENTRY_W = VAL_W + 1;
  localparam int VPN_W   = 36;
  localparam int LEN_W   = 10;
  localparam int CNT_W   = IDX_W + 1;
  localparam int OFF_W   = 12;
  localparam int PA_W    = 52;

  localparam logic [1:0] CMD_MAP       = 2'd0;
  localparam logic [1:0] CMD_UNMAP     = 2'd1;
  localparam logic [1:0] CMD_TRANSLATE = 2'd2;

  localparam logic [1:0] LVL_LEAF = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_CLEAR, S_DISPATCH, S_WALK_RD, S_WALK_EV,
    S_SCAN_RD, S_SCAN_EV, S_FILL
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_ALLOC_ROOT, OP_START_WALK, OP_CLEAR, OP_WALK_RD,
    OP_DESCEND, OP_ALLOC_LINK, OP_I_CLR, OP_SCAN_RD, OP_SCAN_STEP, OP_FILL
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   finish;
    logic   ok;
  } ctrl_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic       run_ok;
    logic       root_present;
    logic       alloc_full;
    logic       entry_valid;
    logic [1:0] lvl;
    logic       idx_last;
    logic       run_last;
  } status_t;
endpackage

FILE: rtl/ptm_ctrl.sv
// Sequencer for map, unmap and translate walks.
`timescale 1ns / 1ps
module ptm_ctrl import ptm_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  status_t stat,
  output ctrl_t   ctl,
  output logic    busy
);
  state_t state, state_next;
  logic   is_tr, bad;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  assign busy  = (state != S_IDLE);
  assign is_tr = (stat.cmd == CMD_TRANSLATE);

  always_comb begin
    state_next = state;
    ctl.op     = OP_NONE;
    ctl.finish = 1'b0;
    ctl.ok     = 1'b0;
    bad        = (stat.cmd == CMD_MAP) ? stat.entry_valid : !stat.entry_valid;
    case (state)
      S_IDLE: begin
        if (start) begin
          ctl.op     = OP_LOAD;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat.cmd != CMD_MAP && stat.cmd != CMD_UNMAP && !is_tr) begin
          ctl.finish = 1'b1;
          state_next = S_IDLE;
        end else if (!is_tr && !stat.run_ok) begin
          ctl.finish = 1'b1;
          state_next = S_IDLE;
        end else if (!stat.root_present) begin
          if (stat.cmd == CMD_MAP && !stat.alloc_full) begin
            ctl.op     = OP_ALLOC_ROOT;
            state_next = S_CLEAR;
          end else begin
            ctl.finish = 1'b1;
            state_next = S_IDLE;
          end
        end else begin
          ctl.op     = OP_START_WALK;
          state_next = S_DISPATCH;
        end
      end
      S_CLEAR: begin
        ctl.op = OP_CLEAR;
        if (stat.idx_last) state_next = S_DISPATCH;
      end
      S_DISPATCH: begin
        if (stat.lvl == LVL_LEAF && !is_tr) begin
          ctl.op     = OP_I_CLR;
          state_next = S_SCAN_RD;
        end else begin
          state_next = S_WALK_RD;
        end
      end
      S_WALK_RD: begin
        ctl.op     = OP_WALK_RD;
        state_next = S_WALK_EV;
      end
      S_WALK_EV: begin
        if (stat.entry_valid) begin
          if (is_tr && stat.lvl == LVL_LEAF) begin
            ctl.finish = 1'b1;
            ctl.ok     = 1'b1;
            state_next = S_IDLE;
          end else begin
            ctl.op     = OP_DESCEND;
            state_next = S_DISPATCH;
          end
        end else if (stat.cmd == CMD_MAP && !stat.alloc_full) begin
          ctl.op     = OP_ALLOC_LINK;
          state_next = S_CLEAR;
        end else begin
          ctl.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_SCAN_RD: begin
        ctl.op     = OP_SCAN_RD;
        state_next = S_SCAN_EV;
      end
      S_SCAN_EV: begin
        if (bad) begin
          ctl.finish = 1'b1;
          state_next = S_IDLE;
        end else if (stat.run_last) begin
          ctl.op     = OP_I_CLR;
          state_next = S_FILL;
        end else begin
          ctl.op     = OP_SCAN_STEP;
          state_next = S_SCAN_RD;
        end
      end
      S_FILL: begin
        ctl.op = OP_FILL;
        if (stat.run_last) begin
          ctl.finish = 1'b1;
          ctl.ok     = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule

FILE: rtl/ptm_datapath.sv
// Table store, allocator and walk registers of the page table manager.
`timescale 1ns / 1ps
module ptm_datapath import ptm_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [1:0]           command,
  input  logic [VPN_W-1:0]     page,
  input  logic [VAL_W-1:0]     frame,
  input  logic [LEN_W-1:0]     run_length,
  input  logic [47:0]          virt_addr,
  input  ctrl_t                ctl,
  output status_t              stat,
  output logic                 done,
  output logic                 success,
  output logic [PA_W-1:0]      phys_addr
);
  logic [ENTRY_W-1:0] mem [TABLE_ENTRIES*TABLE_FRAMES];
  logic [ENTRY_W-1:0] rdata, wdata;
  logic [ADDR_W-1:0]  addr;
  logic               we;

  logic [1:0]         cmd;
  logic [VPN_W-1:0]   vpn;
  logic [VAL_W-1:0]   frm;
  logic [LEN_W-1:0]   len;
  logic [OFF_W-1:0]   off;
  logic [TBL_W-1:0]   tbl;
  logic [1:0]         lvl;
  logic [CNT_W-1:0]   i;
  logic [ALLOC_W-1:0] next_free;
  logic               root_present;
  logic [IDX_W-1:0]   widx, lidx;
  logic [IDX_W+1:0]   run_end;

  always_comb begin
    case (lvl)
      2'd0:    widx = vpn[35:27];
      2'd1:    widx = vpn[26:18];
      2'd2:    widx = vpn[17:9];
      default: widx = vpn[8:0];
    endcase
  end

  assign lidx = vpn[IDX_W-1:0] + i[IDX_W-1:0];

  always_comb begin
    addr  = {tbl, widx};
    we    = 1'b0;
    wdata = '0;
    case (ctl.op)
      OP_ALLOC_LINK: begin
        we    = 1'b1;
        wdata = {1'b1, VAL_W'(next_free[TBL_W-1:0])};
      end
      OP_CLEAR: begin
        addr = {tbl, i[IDX_W-1:0]};
        we   = 1'b1;
      end
      OP_SCAN_RD: addr = {tbl, lidx};
      OP_FILL: begin
        addr = {tbl, lidx};
        we   = 1'b1;
        if (cmd == CMD_MAP) wdata = {1'b1, frm + VAL_W'(i)};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end

  always_ff @(posedge clk) begin
    case (ctl.op)
      OP_LOAD: begin
        cmd <= command;
        vpn <= (command == CMD_TRANSLATE) ? virt_addr[47:OFF_W] : page;
        frm <= frame;
        len <= run_length;
        off <= virt_addr[OFF_W-1:0];
      end
      OP_ALLOC_ROOT: begin
        tbl <= '0;
        lvl <= '0;
        i   <= '0;
      end
      OP_START_WALK: begin
        tbl <= '0;
        lvl <= '0;
      end
      OP_CLEAR:     i <= i + CNT_W'(1);
      OP_DESCEND: begin
        tbl <= rdata[TBL_W-1:0];
        lvl <= lvl + 2'd1;
      end
      OP_ALLOC_LINK: begin
        tbl <= next_free[TBL_W-1:0];
        lvl <= lvl + 2'd1;
        i   <= '0;
      end
      OP_I_CLR:     i <= '0;
      OP_SCAN_STEP: i <= i + CNT_W'(1);
      OP_FILL:      i <= i + CNT_W'(1);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      next_free    <= '0;
      root_present <= 1'b0;
      done         <= 1'b0;
    end else begin
      done <= ctl.finish;
      if (ctl.op == OP_ALLOC_ROOT) begin
        next_free    <= next_free + ALLOC_W'(1);
        root_present <= 1'b1;
      end else if (ctl.op == OP_ALLOC_LINK) begin
        next_free <= next_free + ALLOC_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.finish) begin
      success <= ctl.ok;
      if (ctl.ok && cmd == CMD_TRANSLATE) phys_addr <= {rdata[VAL_W-1:0], off};
      else phys_addr <= '0;
    end
  end

  assign run_end = (IDX_W+2)'(vpn[IDX_W-1:0]) + (IDX_W+2)'(len);

  assign stat.cmd          = cmd;
  assign stat.run_ok       = (len != '0) && (len <= LEN_W'(TABLE_ENTRIES)) &&
                             (run_end <= (IDX_W+2)'(TABLE_ENTRIES));
  assign stat.root_present = root_present;
  assign stat.alloc_full   = (next_free >= ALLOC_W'(TABLE_FRAMES));
  assign stat.entry_valid  = rdata[ENTRY_W-1];
  assign stat.lvl          = lvl;
  assign stat.idx_last     = (i[IDX_W-1:0] == IDX_W'(TABLE_ENTRIES - 1));
  assign stat.run_last     = ((i + CNT_W'(1)) == CNT_W'(len));
endmodule

FILE: rtl/four_level_page_table_manager.sv
// Top level of the four-level page table manager.
//
// channel   direction  transfer                 payload
// command   in         start && !busy           command, page, frame, run_length,
//                                               virt_addr
// result    out        done (one cycle)         success, phys_addr
//
// Each walk level passes through dispatch, table store read and evaluate; every
// newly allocated table adds a clear of all 512 of its entries.
// Map/unmap scan the run entry by entry (read, then evaluate), then fill it.
// Sync reset empties the table (allocator and root flag clear); no sweep needed.
// The result strobe cannot be stalled; busy is low again in the done cycle.
`timescale 1ns / 1ps
`include "four_level_page_table_manager_assert.svh"
module four_level_page_table_manager import ptm_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic [1:0]           command,
  input  logic [VPN_W-1:0]     page,
  input  logic [VAL_W-1:0]     frame,
  input  logic [LEN_W-1:0]     run_length,
  input  logic [47:0]          virt_addr,
  output logic                 done,
  output logic                 success,
  output logic [PA_W-1:0]      phys_addr
);
  ctrl_t   ctl;
  status_t stat;

  ptm_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .ctl   (ctl),
    .busy  (busy)
  );

  ptm_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .command    (command),
    .page       (page),
    .frame      (frame),
    .run_length (run_length),
    .virt_addr  (virt_addr),
    .ctl        (ctl),
    .stat       (stat),
    .done       (done),
    .success    (success),
    .phys_addr  (phys_addr)
  );

  `PTM_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
  `PTM_ASSERT_SAME(a_fail_zero, done && !success, phys_addr == '0)
  `PTM_ASSERT_NEXT(a_finish_done, ctl.finish, done && !busy)
  `PTM_ASSERT_SAME(a_alloc_bound, stat.alloc_full, stat.root_present)
endmodule

FILE: verif/testbench.sv
// Testbench for the four-level page table manager: queue-fed driver, result checker.
`timescale 1ns / 1ps
module testbench;
  import ptm_pkg::*;

  localparam logic [1:0] CMD_BAD = 2'd3;
  localparam int LIMIT = 10000000;

  typedef struct {
    logic [1:0]       cmd;
    logic [VPN_W-1:0] page;
    logic [VAL_W-1:0] frame;
    logic [LEN_W-1:0] len;
    logic [47:0]      va;
    bit               drain;
  } op_t;

  typedef struct {
    logic            ok;
    logic [PA_W-1:0] pa;
  } res_t;

  logic clk = 0, rst = 1, start = 0;
  logic busy, done, success;
  logic [1:0] command = 0;
  logic [VPN_W-1:0] page = 0;
  logic [VAL_W-1:0] frame = 0;
  logic [LEN_W-1:0] run_length = 0;
  logic [47:0] virt_addr = 0;
  logic [PA_W-1:0] phys_addr;

  four_level_page_table_manager uut (.*);

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  // shadow page table
  logic [ENTRY_W-1:0] pt_mem [0:TABLE_FRAMES*TABLE_ENTRIES-1];
  int next_tbl;
  bit root_ok;

  op_t  pending[$];
  res_t expected[$];
  int   errors = 0;
  int   cycles = 0;
  bit   xfer = 0;
  int   gap = 0, burst = 0;

  function automatic int pt_idx(int t, int i);
    return t * TABLE_ENTRIES + i;
  endfunction

  function automatic bit pt_alloc(output int t);
    if (next_tbl >= TABLE_FRAMES) return 0;
    t = next_tbl;
    next_tbl++;
    for (int i = 0; i < TABLE_ENTRIES; i++) pt_mem[pt_idx(t, i)] = '0;
    return 1;
  endfunction

  function automatic bit pt_step(input int t, input int i, input bit grow, output int child);
    logic [ENTRY_W-1:0] e;
    e = pt_mem[pt_idx(t, i)];
    if (e[VAL_W]) begin
      child = int'(e[VAL_W-1:0]);
      return 1;
    end
    if (!grow || !pt_alloc(child)) return 0;
    pt_mem[pt_idx(t, i)] = {1'b1, VAL_W'(child)};
    return 1;
  endfunction

  function automatic res_t pt_predict(op_t o);
    res_t r;
    int t, li, n;
    bit grow;
    logic [VAL_W-1:0] fr;
    r.ok = 0;
    r.pa = '0;
    t = 0;
    grow = (o.cmd == CMD_MAP);
    if (o.cmd == CMD_TRANSLATE) begin
      if (!root_ok) return r;
      if (!pt_step(0, int'(o.va[47:39]), 0, t)) return r;
      if (!pt_step(t, int'(o.va[38:30]), 0, t)) return r;
      if (!pt_step(t, int'(o.va[29:21]), 0, t)) return r;
      if (!pt_mem[pt_idx(t, int'(o.va[20:12]))][VAL_W]) return r;
      fr = pt_mem[pt_idx(t, int'(o.va[20:12]))][VAL_W-1:0];
      r.ok = 1;
      r.pa = {fr, o.va[11:0]};
      return r;
    end
    if (o.cmd != CMD_MAP && o.cmd != CMD_UNMAP) return r;
    n = int'(o.len);
    li = int'(o.page[8:0]);
    if (n == 0 || n > TABLE_ENTRIES || li + n > TABLE_ENTRIES) return r;
    if (!root_ok) begin
      if (!grow || !pt_alloc(t)) return r;
      root_ok = 1;
    end
    if (!pt_step(t, int'(o.page[35:27]), grow, t)) return r;
    if (!pt_step(t, int'(o.page[26:18]), grow, t)) return r;
    if (!pt_step(t, int'(o.page[17:9]), grow, t)) return r;
    for (int i = 0; i < n; i++)
      if (pt_mem[pt_idx(t, li + i)][VAL_W] == grow) return r;
    for (int i = 0; i < n; i++)
      pt_mem[pt_idx(t, li + i)] = grow ? {1'b1, o.frame + VAL_W'(i)} : '0;
    r.ok = 1;
    return r;
  endfunction

  always @(posedge clk) begin
    res_t e;
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("tb: failure");
      $finish;
    end else if (!rst) begin
      if (done) begin
        if (expected.size() == 0) begin
          $display("%0t: unexpected result success=%0b pa=%h", $time, success,
                   phys_addr);
          errors++;
        end else begin
          e = expected.pop_front();
          if (success !== e.ok) begin
            $display("%0t: success expected %0b actual %0b", $time, e.ok, success);
            errors++;
          end
          if (phys_addr !== e.pa) begin
            $display("%0t: phys_addr expected %h actual %h", $time, e.pa,
                     phys_addr);
            errors++;
          end
        end
      end
      xfer <= start && !busy;
      if (start && !busy) begin
        op_t o;
        o.cmd = command; o.page = page; o.frame = frame;
        o.len = run_length; o.va = virt_addr; o.drain = 0;
        expected.push_back(pt_predict(o));
      end
    end
  end

  always @(negedge clk) begin
    bit go;
    op_t o;
    if (!rst && !(start && !xfer)) begin
      go = 0;
      if (gap > 0) gap--;
      else if (pending.size() != 0 && !(pending[0].drain && expected.size() != 0)) begin
        go = 1;
        o = pending.pop_front();
        command <= o.cmd;
        page <= o.page;
        frame <= o.frame;
        run_length <= o.len;
        virt_addr <= o.va;
        if (burst > 0) burst--;
        else begin
          burst = $urandom_range(0, 30);
          gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
        end
      end
      start <= go;
    end
  end

  function automatic op_t mk(logic [1:0] c, logic [VPN_W-1:0] p, logic [VAL_W-1:0] f,
                             logic [LEN_W-1:0] l, logic [47:0] v);
    op_t o;
    o.cmd = c; o.page = p; o.frame = f; o.len = l; o.va = v; o.drain = 0;
    return o;
  endfunction

  function automatic logic [63:0] rnd64();
    return {$urandom, $urandom};
  endfunction

  initial begin
    logic [VPN_W-1:0] bases [6];
    logic [VPN_W-1:0] p;
    op_t o;
    int r, l;
    next_tbl = 0;
    root_ok = 0;
    for (int i = 0; i < 6; i++) bases[i] = VPN_W'(rnd64()) & ~VPN_W'(511);
    bases[1] = {bases[0][35:18], bases[1][17:0]};
    bases[2] = {bases[0][35:27], bases[2][26:0]};
    bases[3] = {VPN_W{1'b1}} & ~VPN_W'(511);

    // directed
    pending.push_back(mk(CMD_TRANSLATE, 0, 0, 0, 48'h0));
    pending.push_back(mk(CMD_UNMAP, 0, 0, 1, 0));
    pending.push_back(mk(CMD_MAP, 0, 0, 0, 0));
    pending.push_back(mk(CMD_MAP, 0, 0, 513, 0));
    pending.push_back(mk(CMD_MAP, 0, 0, 1023, 0));
    pending.push_back(mk(CMD_MAP, 500, 5, 20, 0));
    pending.push_back(mk(CMD_MAP, 0, 40'h12345, 1, 0));
    pending.push_back(mk(CMD_TRANSLATE, 0, 0, 0, 48'h000000000abc));
    pending.push_back(mk(CMD_MAP, 0, 7, 1, 0));
    pending.push_back(mk(CMD_UNMAP, 0, 0, 2, 0));
    pending.push_back(mk(CMD_UNMAP, 0, 0, 1, 0));
    pending.push_back(mk(CMD_TRANSLATE, 0, 0, 0, 48'h000000000abc));
    pending.push_back(mk(CMD_MAP, bases[3], {VAL_W{1'b1}} - 40'd3, 512, 0));
    pending.push_back(mk(CMD_TRANSLATE, 0, 0, 0, {48{1'b1}}));
    pending.push_back(mk(CMD_MAP, bases[3] | 36'd511, 1, 1, 0));
    pending.push_back(mk(CMD_UNMAP, bases[3] | 36'd511, 0, 1, 0));
    pending.push_back(mk(CMD_UNMAP, bases[3] | 36'd511, 0, 1, 0));
    pending.push_back(mk(CMD_BAD, 0, 0, 1, {48{1'b1}}));
    o = mk(CMD_UNMAP, bases[3], 0, 511, 0);
    o.drain = 1;
    pending.push_back(o);

    // random
    for (int n = 0; n < 1000; n++) begin
      r = $urandom_range(0, 99);
      p = bases[$urandom_range(0, 5)] | VPN_W'($urandom_range(0, 511));
      l = ($urandom_range(0, 30) == 0) ? $urandom_range(1, 512) : $urandom_range(1, 16);
      if (r < 38) o = mk(CMD_MAP, p, VAL_W'(rnd64()), LEN_W'(l), 48'(rnd64()));
      else if (r < 62) o = mk(CMD_UNMAP, p, VAL_W'(rnd64()), LEN_W'(l), 48'(rnd64()));
      else if (r < 88) o = mk(CMD_TRANSLATE, VPN_W'(rnd64()), VAL_W'(rnd64()), LEN_W'(l),
                             {p, 12'($urandom)});
      else if (r < 92) o = mk(CMD_TRANSLATE, p, 0, 0, 48'(rnd64()));
      else if (r < 96) o = mk(CMD_MAP, VPN_W'(rnd64()), VAL_W'(rnd64()),
                             LEN_W'($urandom_range(0, 8)), 48'(rnd64()));
      else o = mk(($urandom_range(0, 1) != 0) ? CMD_BAD : CMD_UNMAP, VPN_W'(rnd64()),
                  VAL_W'(rnd64()), LEN_W'($urandom), 48'(rnd64()));
      o.drain = (n == 500);
      pending.push_back(o);
    end

    repeat (5) @(posedge clk);
    @(negedge clk) rst = 0;
    wait (pending.size() == 0 && !start && expected.size() == 0);
    repeat (50) @(posedge clk);
    if (errors == 0 && expected.size() == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end
endmodule
